### hw/rtl/dhrb_pkg.sv
// ----------------------------------------------------------------------------
// dhrb_pkg: shared definitions for the history ring browser
// Request and response types, request kinds, status codes and default sizes.
// ----------------------------------------------------------------------------
package dhrb_pkg;

    // Default number of kept identifiers.
    localparam int DEPTH_DEFAULT = 16;

    // Number of leading characters of an identifier that are kept.
    localparam int KEY_CHARS = 8;

    // Identifier width in bits.
    localparam int ID_W = 64;

    // Request kinds.
    localparam logic [2:0] KIND_ADD   = 3'd0;
    localparam logic [2:0] KIND_OLDER = 3'd1;
    localparam logic [2:0] KIND_NEWER = 3'd2;
    localparam logic [2:0] KIND_SHOW  = 3'd3;
    localparam logic [2:0] KIND_RESET = 3'd4;

    // Response status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REPEAT  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NO_MOVE = 2'd3;

    // Request payload.
    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] id;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] shown_id;
        logic [4:0]      entry_count;
        logic [3:0]      cursor_age;
    } rsp_t;

endpackage

### hw/rtl/dhrb_ram.sv
// ----------------------------------------------------------------------------
// dhrb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dhrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/dedup_history_ring_browser.sv
// ----------------------------------------------------------------------------
// dedup_history_ring_browser: bounded identifier history with a browse cursor
// Keeps the newest identifiers in a ring RAM and serves cursor requests.
// ----------------------------------------------------------------------------
// The block takes one request in every cycle unless req_stall is high, and
// gives its response in the cycle after acceptance, set by the registered read
// port of the entry RAM, which the response register shares. Requests keep
// flowing while the response side is taken, and the request side stalls only
// while a response waits on a stalled consumer. The entry RAM needs no
// clearing after reset, since an entry is only read once it has been written,
// so the block accepts requests from the first cycle after reset.
module dedup_history_ring_browser #(
    parameter int DEPTH = dhrb_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dhrb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dhrb_pkg::rsp_t rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Control state.
    logic [PTR_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] cursor_reg, cursor_next;
    logic             rsp_valid_reg;

    // Newest entry kept beside the RAM for the repeat test.
    logic [dhrb_pkg::ID_W-1:0] newest_reg, newest_next;

    // Response payload held with the RAM read data.
    logic [1:0]                status_reg, status_next;
    logic [dhrb_pkg::ID_W-1:0] hold_reg, hold_next;
    logic                      use_ram_reg, use_ram_next;

    logic                      accept;
    logic [dhrb_pkg::ID_W-1:0] key;
    logic [PTR_W-1:0]          rd_age;
    logic [PTR_W-1:0]          rd_addr;
    logic [PTR_W-1:0]          wr_addr;
    logic                      wr_req;
    logic [dhrb_pkg::ID_W-1:0] rd_data;

    // Keep the leading characters up to the first zero byte.
    function automatic logic [dhrb_pkg::ID_W-1:0] normalize_key(
        input logic [dhrb_pkg::ID_W-1:0] id
    );
        logic [dhrb_pkg::ID_W-1:0] k;
        logic                      alive;
        logic [7:0]                b;
        k     = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            b = id[dhrb_pkg::ID_W-1-8*i -: 8];
            if (i >= dhrb_pkg::KEY_CHARS || b == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                k[dhrb_pkg::ID_W-1-8*i -: 8] = b;
            end
        end
        return k;
    endfunction

    // Ring slot of the entry at a given age, where age zero is the newest.
    function automatic logic [PTR_W-1:0] slot_of_age(
        input logic [PTR_W-1:0] oldest,
        input logic [CNT_W-1:0] count,
        input logic [PTR_W-1:0] age
    );
        logic [CNT_W-1:0] back;
        logic [PTR_W:0]   sum;
        back = count - CNT_W'(1) - CNT_W'(age);
        sum  = {1'b0, oldest} + {1'b0, back[PTR_W-1:0]};
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Handshake: hold requests only while a response is stuck.
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    // Request decode and next state.
    always_comb
    begin
        key          = normalize_key(req.id);
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        newest_next  = newest_reg;
        status_next  = dhrb_pkg::ST_DONE;
        hold_next    = '0;
        use_ram_next = 1'b0;
        wr_req       = 1'b0;
        rd_age       = cursor_reg;

        // Append goes after the newest, or over the oldest when full.
        if (count_reg >= CNT_W'(DEPTH))
        begin
            wr_addr = oldest_reg;
        end
        else
        begin
            wr_addr = slot_of_age(oldest_reg, count_reg + CNT_W'(1), '0);
        end

        case (req.kind)
            dhrb_pkg::KIND_ADD:
            begin
                if (key == '0)
                begin
                    status_next  = dhrb_pkg::ST_EMPTY;
                    use_ram_next = (count_reg != '0);
                end
                else if (count_reg != '0 && newest_reg == key)
                begin
                    status_next = dhrb_pkg::ST_REPEAT;
                    cursor_next = '0;
                    hold_next   = key;
                end
                else
                begin
                    wr_req      = 1'b1;
                    newest_next = key;
                    cursor_next = '0;
                    hold_next   = key;
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        if (oldest_reg == PTR_W'(DEPTH - 1))
                        begin
                            oldest_next = '0;
                        end
                        else
                        begin
                            oldest_next = oldest_reg + PTR_W'(1);
                        end
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            dhrb_pkg::KIND_OLDER:
            begin
                if (count_reg == '0 || CNT_W'(cursor_reg) >= count_reg - CNT_W'(1))
                begin
                    status_next = dhrb_pkg::ST_NO_MOVE;
                end
                else
                begin
                    cursor_next  = cursor_reg + PTR_W'(1);
                    rd_age       = cursor_reg + PTR_W'(1);
                    use_ram_next = 1'b1;
                end
            end
            dhrb_pkg::KIND_NEWER:
            begin
                if (cursor_reg == '0 || count_reg == '0)
                begin
                    status_next = dhrb_pkg::ST_NO_MOVE;
                end
                else
                begin
                    cursor_next  = cursor_reg - PTR_W'(1);
                    rd_age       = cursor_reg - PTR_W'(1);
                    use_ram_next = 1'b1;
                end
            end
            default:
            begin
                // Show current; cursor reset and unused kinds share this path.
                if (req.kind == dhrb_pkg::KIND_RESET)
                begin
                    cursor_next = '0;
                    rd_age      = '0;
                end
                if (count_reg == '0)
                begin
                    status_next = dhrb_pkg::ST_NO_MOVE;
                end
                else
                begin
                    use_ram_next = 1'b1;
                end
            end
        endcase

        rd_addr = slot_of_age(oldest_reg, count_reg, rd_age);
    end

    // Entry store.
    dhrb_ram #(
        .WIDTH (dhrb_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (accept & wr_req),
        .wr_addr (wr_addr),
        .wr_data (key),
        .rd_en   (accept & use_ram_next),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg    <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                oldest_reg <= oldest_next;
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            newest_reg  <= newest_next;
            status_reg  <= status_next;
            hold_reg    <= hold_next;
            use_ram_reg <= use_ram_next;
        end
    end

    // Response; the count and cursor registers already hold the new values.
    assign rsp_valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.shown_id     = use_ram_reg ? rd_data : hold_reg;
    assign rsp.entry_count  = 5'(count_reg);
    assign rsp.cursor_age   = 4'(cursor_reg);

    // The kept count never exceeds the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("kept count above depth");

    // The cursor stays within the kept entries.
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && cursor_reg == '0) ||
        (count_reg != '0 && CNT_W'(cursor_reg) < count_reg))
        else $error("cursor outside kept range");

    // The kept count never falls.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("kept count decreased");

    // State and read data hold while a response is stalled.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=>
        ($stable(count_reg) && $stable(cursor_reg) && $stable(rsp.shown_id)))
        else $error("state moved under a stalled response");

    // A refused move or empty history shows no entry.
    a_no_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp.status == dhrb_pkg::ST_NO_MOVE) |-> rsp.shown_id == '0)
        else $error("entry shown with no-move status");

endmodule
